FILE: hdl/esp_pkg.sv
// ----------------------------------------------------------------------------
// Encoder speed/position shared definitions
// Types, constants and state encodings used by the front queue, the back
// sequencer and the top level.
// ----------------------------------------------------------------------------
package esp_pkg;

    // Default length of the timestamp ring.
    localparam int WINDOW_DEF = 50;

    // Field widths.
    localparam int CPR_W  = 12;
    localparam int TIME_W = 32;
    localparam int TICK_W = 32;
    localparam int RPM_W  = 16;
    localparam int POS_W  = 13;

    // Divider width used for the RPM step; the product is compared to 60000.
    localparam int DEN_W  = 16;

    // counts_per_rev value after reset.
    localparam logic [CPR_W-1:0] CPR_RESET = 12'd300;

    // Numerator of the speed formula (ms per minute).
    localparam logic [RPM_W-1:0] RPM_NUM = 16'd60000;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Classified operation.
    typedef enum logic [0:0] {
        OP_EDGE  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // One queued transaction.
    typedef struct packed {
        t_op               op;
        logic              phase_b;
        logic [TIME_W-1:0] time_ms;
    } t_item;

    // Back sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_AVG,
        ST_MUL,
        ST_CHK,
        ST_RPM,
        ST_FINISH
    } t_state;

endpackage

FILE: hdl/esp_front.sv
// ----------------------------------------------------------------------------
// Encoder speed/position front end
// Accepts input transactions, classifies them as edge or query and holds them
// in a short queue so the input side keeps moving while the back end works.
// ----------------------------------------------------------------------------
module esp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic                              i_phase_b,
    input  logic [esp_pkg::TIME_W-1:0]        i_time_ms,
    output logic                              o_q_valid,
    output esp_pkg::t_item                    o_q_item,
    input  logic                              i_q_pop
);

    esp_pkg::t_item                       r_mem [esp_pkg::QUEUE_DEPTH];
    logic [esp_pkg::QUEUE_PTR_W-1:0]      r_wr_ptr;
    logic [esp_pkg::QUEUE_PTR_W-1:0]      r_rd_ptr;
    logic [esp_pkg::QUEUE_CNT_W-1:0]      r_count;
    logic                                 full;
    logic                                 push;
    logic                                 pop;
    esp_pkg::t_item                       item;

    assign full       = (r_count == esp_pkg::QUEUE_CNT_W'(esp_pkg::QUEUE_DEPTH));
    assign o_in_stall = full;
    assign push       = i_in_valid && !full;
    assign pop        = i_q_pop && (r_count != '0);
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];

    // Classify the incoming transaction.
    always_comb begin
        item.op      = i_cmd ? esp_pkg::OP_QUERY : esp_pkg::OP_EDGE;
        item.phase_b = i_phase_b;
        item.time_ms = i_time_ms;
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/esp_div.sv
// ----------------------------------------------------------------------------
// Encoder speed/position serial divider
// Restoring unsigned divider, one quotient bit per cycle. Quotient and
// remainder hold once busy drops until the next start.
// ----------------------------------------------------------------------------
module esp_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign shifted = {r_rem, r_num[NUM_W-1]};
    assign ge      = (shifted >= {1'b0, r_den});
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

FILE: hdl/esp_back.sv
// ----------------------------------------------------------------------------
// Encoder speed/position back end
// Applies edge transactions to the counters and the timestamp ring, and runs
// queries: the position remainder and, once the ring is full, a sweep of the ring,
// the average and, if in range, the RPM division, ending in a registered result.
// ----------------------------------------------------------------------------
module esp_back #(
    parameter int WINDOW = esp_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [esp_pkg::CPR_W-1:0]           i_cfg_data,
    input  logic                                i_q_valid,
    input  esp_pkg::t_item                      i_q_item,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [esp_pkg::RPM_W-1:0]           o_rpm,
    output logic signed [esp_pkg::POS_W-1:0]    o_position,
    output logic signed [esp_pkg::TICK_W-1:0]   o_tick_total,
    output logic                                o_speed_valid,
    output logic                                o_overspeed
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = esp_pkg::TIME_W + $clog2(WINDOW);
    localparam int PROD_W = esp_pkg::DEN_W + esp_pkg::CPR_W;

    // Sums at or above this limit give an average above 60000, so the speed is zero.
    localparam int AVG_LIMIT = (WINDOW - 1) * (int'(esp_pkg::RPM_NUM) + 1);
    localparam int AVG_X_W   = $clog2(AVG_LIMIT);
    localparam int RECIP_SH  = AVG_X_W + $clog2(WINDOW - 1);
    localparam int RECIP_W   = AVG_X_W + 1;
    localparam int AVG_P_W   = AVG_X_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(WINDOW - 2)) / 64'(WINDOW - 1);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_FULL);

    // Timestamp ring.
    logic [esp_pkg::TIME_W-1:0] r_ring [WINDOW];
    logic [esp_pkg::TIME_W-1:0] r_rd_data;

    // Architectural state.
    logic [esp_pkg::CPR_W-1:0]  r_cpr;
    logic [SLOT_W-1:0]          r_slot;
    logic [CNT_W-1:0]           r_seen;
    logic [esp_pkg::TICK_W-1:0] r_ticks;

    // Sequencer and sweep.
    esp_pkg::t_state            r_state;
    esp_pkg::t_state            n_state;
    logic [CNT_W-1:0]           r_k;
    logic [SLOT_W-1:0]          r_addr;
    logic [esp_pkg::TIME_W-1:0] r_prev;
    logic [SUM_W-1:0]           r_sum;
    logic [SUM_W-1:0]           n_sum;
    logic [esp_pkg::TIME_W-1:0] diff;

    // Speed arithmetic.
    logic [esp_pkg::DEN_W-1:0]  r_avg;
    logic [PROD_W-1:0]          r_denom;
    logic [esp_pkg::RPM_W-1:0]  r_rpm;
    logic                       r_sv;
    logic                       r_ov;
    logic [esp_pkg::CPR_W-1:0]  cpr_eff;
    logic                       window_full;
    logic                       sweep_last;
    logic                       denom_ok;
    logic                       avg_big;
    logic [AVG_P_W-1:0]         avg_prod;

    // Dividers.
    logic                       div_start;
    logic [esp_pkg::RPM_W-1:0]  div_num;
    logic [esp_pkg::DEN_W-1:0]  div_den;
    logic                       div_busy;
    logic [esp_pkg::RPM_W-1:0]  div_quo;
    logic [esp_pkg::DEN_W-1:0]  div_rem;
    logic                       pos_start;
    logic [esp_pkg::TICK_W-1:0] pos_mag;
    logic                       pos_busy;
    logic [esp_pkg::TICK_W-1:0] pos_quo;
    logic [esp_pkg::CPR_W-1:0]  pos_rem;
    logic [esp_pkg::POS_W-1:0]  pos_val;

    // Output register.
    logic                       r_out_valid;
    logic [esp_pkg::RPM_W-1:0]  r_out_rpm;
    logic [esp_pkg::POS_W-1:0]  r_out_pos;
    logic [esp_pkg::TICK_W-1:0] r_out_ticks;
    logic                       r_out_sv;
    logic                       r_out_ov;
    logic                       out_free;
    logic                       out_load;
    logic                       take_edge;
    logic                       take_query;

    assign cpr_eff     = (r_cpr == '0) ? esp_pkg::CPR_W'(1) : r_cpr;
    assign window_full = (r_seen == CNT_W'(WINDOW));
    assign sweep_last  = (r_k == CNT_W'(WINDOW));
    assign out_free    = !r_out_valid || !i_out_stall;
    assign denom_ok    = (r_denom != '0) && (r_denom <= PROD_W'(esp_pkg::RPM_NUM));

    // Running sum of consecutive timestamp differences, each modulo 2^32.
    assign diff  = r_rd_data - r_prev;
    assign n_sum = (r_k >= CNT_W'(2)) ? r_sum + SUM_W'(diff) : r_sum;

    // Average period by reciprocal multiplication; exact for every sum below the limit.
    assign avg_big  = (r_sum >= SUM_W'(AVG_LIMIT));
    assign avg_prod = AVG_P_W'(r_sum[AVG_X_W-1:0]) * AVG_P_W'(RECIP_M);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            esp_pkg::ST_IDLE: begin
                if (i_q_valid && (i_q_item.op == esp_pkg::OP_QUERY)) begin
                    n_state = window_full ? esp_pkg::ST_SWEEP : esp_pkg::ST_FINISH;
                end
            end
            esp_pkg::ST_SWEEP: begin
                if (sweep_last) begin
                    n_state = esp_pkg::ST_AVG;
                end
            end
            esp_pkg::ST_AVG: begin
                n_state = avg_big ? esp_pkg::ST_FINISH : esp_pkg::ST_MUL;
            end
            esp_pkg::ST_MUL: begin
                n_state = esp_pkg::ST_CHK;
            end
            esp_pkg::ST_CHK: begin
                n_state = denom_ok ? esp_pkg::ST_RPM : esp_pkg::ST_FINISH;
            end
            esp_pkg::ST_RPM: begin
                if (!div_busy) begin
                    n_state = esp_pkg::ST_FINISH;
                end
            end
            esp_pkg::ST_FINISH: begin
                if (!pos_busy && out_free) begin
                    n_state = esp_pkg::ST_IDLE;
                end
            end
            default: n_state = esp_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_q_pop    = 1'b0;
        take_edge  = 1'b0;
        take_query = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            esp_pkg::ST_IDLE: begin
                o_q_pop    = i_q_valid;
                take_edge  = i_q_valid && (i_q_item.op == esp_pkg::OP_EDGE);
                take_query = i_q_valid && (i_q_item.op == esp_pkg::OP_QUERY);
            end
            esp_pkg::ST_CHK:    div_start = denom_ok;
            esp_pkg::ST_FINISH: out_load  = !pos_busy && out_free;
            default: begin
            end
        endcase
    end

    assign pos_start = take_query;
    assign pos_mag   = r_ticks[esp_pkg::TICK_W-1] ? (~r_ticks + 1'b1) : r_ticks;
    assign div_num   = esp_pkg::RPM_NUM;
    assign div_den   = r_denom[esp_pkg::DEN_W-1:0];

    // RPM is 60000 divided by the period product.
    esp_div #(
        .NUM_W (esp_pkg::RPM_W),
        .DEN_W (esp_pkg::DEN_W)
    ) u_div_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // Position remainder runs alongside the ring sweep.
    esp_div #(
        .NUM_W (esp_pkg::TICK_W),
        .DEN_W (esp_pkg::CPR_W)
    ) u_div_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pos_start),
        .i_num   (pos_mag),
        .i_den   (cpr_eff),
        .o_busy  (pos_busy),
        .o_quo   (pos_quo),
        .o_rem   (pos_rem)
    );

    // Remainder takes the sign of the count.
    assign pos_val = r_ticks[esp_pkg::TICK_W-1] ? (~{1'b0, pos_rem} + 1'b1) : {1'b0, pos_rem};

    // Ring write on an edge and registered read for the sweep.
    always_ff @(posedge i_clk) begin
        if (take_edge) begin
            r_ring[r_slot] <= i_q_item.time_ms;
        end
        r_rd_data <= r_ring[r_addr];
    end

    // Configuration, counters and state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esp_pkg::ST_IDLE;
            r_cpr   <= esp_pkg::CPR_RESET;
            r_slot  <= '0;
            r_seen  <= '0;
            r_ticks <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cpr <= i_cfg_data;
            end
            if (take_edge) begin
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (!window_full) begin
                    r_seen <= r_seen + 1'b1;
                end
                r_ticks <= i_q_item.phase_b ? r_ticks + 1'b1 : r_ticks - 1'b1;
            end
        end
    end

    // Ring sweep, oldest entry first.
    always_ff @(posedge i_clk) begin
        if (take_query) begin
            r_k    <= '0;
            r_addr <= r_slot;
            r_sum  <= '0;
        end else if (r_state == esp_pkg::ST_SWEEP) begin
            r_sum <= n_sum;
            if (r_k >= CNT_W'(1)) begin
                r_prev <= r_rd_data;
            end
            if (!sweep_last) begin
                r_k    <= r_k + 1'b1;
                r_addr <= (r_addr == SLOT_W'(WINDOW - 1)) ? '0 : r_addr + 1'b1;
            end
        end
    end

    // Speed result.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            esp_pkg::ST_IDLE: begin
                if (take_query) begin
                    r_rpm <= '0;
                    r_sv  <= window_full;
                    r_ov  <= 1'b0;
                end
            end
            esp_pkg::ST_AVG: begin
                r_avg <= avg_prod[RECIP_SH +: esp_pkg::DEN_W];
            end
            esp_pkg::ST_MUL: begin
                r_denom <= PROD_W'(r_avg) * PROD_W'(cpr_eff);
            end
            esp_pkg::ST_CHK: begin
                if (r_denom == '0) begin
                    r_rpm <= esp_pkg::RPM_NUM;
                    r_ov  <= 1'b1;
                end
            end
            esp_pkg::ST_RPM: begin
                if (!div_busy) begin
                    r_rpm <= div_quo;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rpm   <= r_rpm;
            r_out_pos   <= pos_val;
            r_out_ticks <= r_ticks;
            r_out_sv    <= r_sv;
            r_out_ov    <= r_ov;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rpm         = r_out_rpm;
    assign o_position    = r_out_pos;
    assign o_tick_total  = r_out_ticks;
    assign o_speed_valid = r_out_sv;
    assign o_overspeed   = r_out_ov;

`ifndef SYNTH
    // The edge count never runs past the ring length.
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CNT_W'(WINDOW))
        else $error("edge count exceeds ring length");

    // The write slot always points inside the ring.
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(WINDOW - 1))
        else $error("write slot outside ring");

    // The speed divider is only started when it is free.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("speed divider restarted while busy");

    // The queue is only drained by the idle sequencer.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == esp_pkg::ST_IDLE))
        else $error("queue popped during a query");

    // An overspeed result is always a valid, saturated speed.
    a_overspeed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ov) |-> (r_out_sv && (r_out_rpm == esp_pkg::RPM_NUM)))
        else $error("overspeed without saturated valid speed");
`endif

endmodule

FILE: hdl/encoder_speed_position_top.sv
// An edge is applied when the idle sequencer pops it from the queue; a query with a full ring
// returns after the ring sweep at one entry per cycle and, when it runs, the 16-step RPM divider;
// a query before the ring fills returns once the position divider is done. Throughput: one
// edge per cycle while the queue has room and no query is running, one query at a time.
// Synchronous active-low reset clears the counters, queue and output and restores
// counts_per_rev to 300; the timestamp ring is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// Encoder speed/position top level
// Quadrature edge counter with windowed speed measurement: a front queue
// feeding a back-end sequencer.
// ----------------------------------------------------------------------------
module encoder_speed_position_top #(
    parameter int WINDOW = esp_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [esp_pkg::CPR_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_cmd,
    input  logic                                i_phase_b,
    input  logic [esp_pkg::TIME_W-1:0]          i_time_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [esp_pkg::RPM_W-1:0]           o_rpm,
    output logic signed [esp_pkg::POS_W-1:0]    o_position,
    output logic signed [esp_pkg::TICK_W-1:0]   o_tick_total,
    output logic                                o_speed_valid,
    output logic                                o_overspeed
);

    logic           q_valid;
    esp_pkg::t_item q_item;
    logic           q_pop;

    // Accept and classify transactions.
    esp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_phase_b  (i_phase_b),
        .i_time_ms  (i_time_ms),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    // Count edges and answer queries.
    esp_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rpm         (o_rpm),
        .o_position    (o_position),
        .o_tick_total  (o_tick_total),
        .o_speed_valid (o_speed_valid),
        .o_overspeed   (o_overspeed)
    );

endmodule

FILE: dv/encoder_speed_position_top_test.sv
// ----------------------------------------------------------------------------
// Encoder speed/position regression bench
// Drives edge and query transactions into the encoder block under random
// idling and output stalls, and checks every speed/position report against its
// typed-in value or a cycle-free predictor of counter, timestamp ring and divider.
// ----------------------------------------------------------------------------
module encoder_speed_position_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 120;
    localparam int SHOWN_ERRORS  = 10;

    // One speed/position report as it leaves the block.
    typedef struct packed {
        logic [esp_pkg::RPM_W-1:0]         rpm;
        logic signed [esp_pkg::POS_W-1:0]  position;
        logic signed [esp_pkg::TICK_W-1:0] tick_total;
        logic                              speed_valid;
        logic                              overspeed;
    } t_report;

    // One row of the directed stimulus; known reports are typed in.
    typedef struct packed {
        esp_pkg::t_op               op;
        logic                       phase_b;
        logic [esp_pkg::TIME_W-1:0] time_ms;
        logic                       typed;
        t_report                    want;
    } t_vector;

    localparam t_report NO_SPEED = '{16'd0, 13'sd0, 32'sd0, 1'b0, 1'b0};

    localparam t_vector DIRECTED_ROWS [16] = '{
        '{esp_pkg::OP_QUERY, 1'b0, 32'h0000_0000, 1'b1, NO_SPEED},
        '{esp_pkg::OP_QUERY, 1'b1, 32'hFFFF_FFFF, 1'b1, NO_SPEED},
        '{esp_pkg::OP_EDGE,  1'b1, 32'h0000_0000, 1'b0, NO_SPEED},
        '{esp_pkg::OP_QUERY, 1'b0, 32'h0000_0000, 1'b1,
          '{16'd0, 13'sd1, 32'sd1, 1'b0, 1'b0}},
        '{esp_pkg::OP_EDGE,  1'b0, 32'hFFFF_FFFF, 1'b0, NO_SPEED},
        '{esp_pkg::OP_EDGE,  1'b0, 32'h0000_0000, 1'b0, NO_SPEED},
        '{esp_pkg::OP_EDGE,  1'b0, 32'h0000_0001, 1'b0, NO_SPEED},
        '{esp_pkg::OP_QUERY, 1'b1, 32'h8000_0000, 1'b1,
          '{16'd0, -13'sd2, -32'sd2, 1'b0, 1'b0}},
        '{esp_pkg::OP_EDGE,  1'b1, 32'h7FFF_FFFF, 1'b0, NO_SPEED},
        '{esp_pkg::OP_EDGE,  1'b1, 32'h8000_0000, 1'b0, NO_SPEED},
        '{esp_pkg::OP_EDGE,  1'b0, 32'hAAAA_AAAA, 1'b0, NO_SPEED},
        '{esp_pkg::OP_EDGE,  1'b1, 32'h5555_5555, 1'b0, NO_SPEED},
        '{esp_pkg::OP_QUERY, 1'b0, 32'h0000_0000, 1'b0, NO_SPEED},
        '{esp_pkg::OP_EDGE,  1'b1, 32'hFFFF_FFFE, 1'b0, NO_SPEED},
        '{esp_pkg::OP_EDGE,  1'b1, 32'hFFFF_FFFF, 1'b0, NO_SPEED},
        '{esp_pkg::OP_QUERY, 1'b0, 32'hAAAA_5555, 1'b0, NO_SPEED}
    };

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [esp_pkg::CPR_W-1:0]         i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic                              i_cmd;
    logic                              i_phase_b;
    logic [esp_pkg::TIME_W-1:0]        i_time_ms;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [esp_pkg::RPM_W-1:0]         o_rpm;
    logic signed [esp_pkg::POS_W-1:0]  o_position;
    logic signed [esp_pkg::TICK_W-1:0] o_tick_total;
    logic                              o_speed_valid;
    logic                              o_overspeed;

    // Predictor state: timestamp ring, counters and the register copy.
    logic [esp_pkg::TIME_W-1:0] stamp_ring [esp_pkg::WINDOW_DEF];
    int unsigned                ring_slot;
    int unsigned                ring_fill;
    logic [esp_pkg::TICK_W-1:0] shaft_ticks;
    logic [esp_pkg::CPR_W-1:0]  cpr_setting;

    // Reports still owed by the block, oldest first.
    t_report pending_reports [$];

    bit steady;
    int error_count;
    int items_sent;
    int reports_checked;
    int full_window_reports;
    int overspeed_reports;
    int peak_rpm;
    int settings_used;
    int quiet_cycles;

    encoder_speed_position_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_phase_b     (i_phase_b),
        .i_time_ms     (i_time_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rpm         (o_rpm),
        .o_position    (o_position),
        .o_tick_total  (o_tick_total),
        .o_speed_valid (o_speed_valid),
        .o_overspeed   (o_overspeed)
    );

    // Free-running clock.
    always #4 i_clk = ~i_clk;

    // Records a failure; only the first ten are printed.
    function automatic void note_failure(input string what);
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
            $display("[%0t] ERROR: %s", $time, what);
        end
    endfunction

    // Advances the counter and the timestamp ring by one encoder edge.
    function automatic void record_edge(input logic phase_b,
                                        input logic [esp_pkg::TIME_W-1:0] stamp);
        stamp_ring[ring_slot] = stamp;
        ring_slot = (ring_slot + 1 == esp_pkg::WINDOW_DEF) ? 0 : ring_slot + 1;
        if (ring_fill < esp_pkg::WINDOW_DEF) begin
            ring_fill++;
        end
        shaft_ticks = phase_b ? shaft_ticks + 1'b1 : shaft_ticks - 1'b1;
    endfunction

    // Computes the speed and position report that a query returns now.
    function automatic t_report speed_report();
        t_report                    rep;
        longint unsigned            span;
        longint unsigned            avg;
        longint unsigned            denom;
        logic [esp_pkg::TIME_W-1:0] gap;
        longint                     ticks;
        longint                     rem;
        longint                     divisor;
        int unsigned                k;
        rep = '0;
        divisor = (cpr_setting == '0) ? 1 : longint'(cpr_setting);
        if (ring_fill >= esp_pkg::WINDOW_DEF) begin
            span = 0;
            // Each gap wraps at 32 bits, so a clock rollover leaves the sum intact.
            for (k = 1; k < esp_pkg::WINDOW_DEF; k++) begin
                gap = stamp_ring[(ring_slot + k) % esp_pkg::WINDOW_DEF]
                    - stamp_ring[(ring_slot + k - 1) % esp_pkg::WINDOW_DEF];
                span += 64'(gap);
            end
            avg = span / (esp_pkg::WINDOW_DEF - 1);
            denom = avg * longint'(divisor);
            rep.speed_valid = 1'b1;
            if (denom == 0) begin
                rep.rpm = esp_pkg::RPM_NUM;
                rep.overspeed = 1'b1;
            end else begin
                rep.rpm = esp_pkg::RPM_W'(longint'(esp_pkg::RPM_NUM) / denom);
            end
        end
        ticks = longint'($signed(shaft_ticks));
        rem = ticks % divisor;
        rep.position = rem[esp_pkg::POS_W-1:0];
        rep.tick_total = shaft_ticks;
        return rep;
    endfunction

    // Sends one transaction and books the report it is owed, if any.
    task automatic send_item(input esp_pkg::t_op op, input logic phase_b,
                             input logic [esp_pkg::TIME_W-1:0] stamp,
                             input logic typed, input t_report want);
        while (!steady && $urandom_range(99, 0) < 20) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= op;
        i_phase_b  <= phase_b;
        i_time_ms  <= stamp;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
        if (op == esp_pkg::OP_EDGE) begin
            record_edge(phase_b, stamp);
        end else begin
            pending_reports.push_back(typed ? want : speed_report());
        end
        @(negedge i_clk);
    endtask

    // Stops sending, waits for all owed reports and lets queued edges finish.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes counts_per_rev while the block is idle.
    task automatic write_cpr(input logic [esp_pkg::CPR_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cpr_setting = value;
        settings_used++;
    endtask

    // A stretch of edges at one period with queries mixed in; some are cut
    // short so that the window straddles two different speeds.
    task automatic spin_burst();
        logic [esp_pkg::TIME_W-1:0] stamp;
        logic [esp_pkg::TIME_W-1:0] period;
        logic [esp_pkg::TIME_W-1:0] spread;
        int                         n_edges;
        int                         up_bias;
        int                         k;
        stamp = $urandom();
        case ($urandom_range(5, 0))
            0: begin
                period = '0;
                spread = '0;
            end
            1: begin
                period = $urandom_range(3, 1);
                spread = '0;
            end
            2: begin
                period = $urandom_range(250, 4);
                spread = $urandom_range(3, 0);
            end
            3: begin
                period = $urandom_range(70000, 251);
                spread = $urandom_range(500, 0);
            end
            4: begin
                period = $urandom();
                spread = $urandom();
            end
            default: begin
                period = $urandom_range(20, 0);
                spread = $urandom_range(2, 0);
            end
        endcase
        up_bias = $urandom_range(100, 0);
        n_edges = ($urandom_range(3, 0) == 0) ? $urandom_range(49, 5) : $urandom_range(70, 52);
        for (k = 0; k < n_edges; k++) begin
            if ($urandom_range(5, 0) == 0) begin
                send_item(esp_pkg::OP_QUERY, 1'($urandom_range(1, 0)), $urandom(), 1'b0,
                          NO_SPEED);
            end
            stamp = stamp + period + ((spread == 0) ? 0 : $urandom_range(spread, 0));
            send_item(esp_pkg::OP_EDGE, 1'($urandom_range(99, 0) < up_bias), stamp, 1'b0,
                      NO_SPEED);
        end
        send_item(esp_pkg::OP_QUERY, 1'($urandom_range(1, 0)), $urandom(), 1'b0, NO_SPEED);
    endtask

    // A few transactions with every field random.
    task automatic scatter_noise();
        int n;
        int k;
        n = $urandom_range(8, 3);
        for (k = 0; k < n; k++) begin
            send_item(esp_pkg::t_op'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                      $urandom(), 1'b0, NO_SPEED);
        end
    endtask

    // Receiver side: random output stalls except during the steady phase.
    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99, 0) < 20);
    end

    // Report checker: each accepted report against the oldest owed one.
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_rpm, o_position, o_tick_total, o_speed_valid, o_overspeed};
            if (pending_reports.size() == 0) begin
                note_failure($sformatf("report with none owed: rpm %0d pos %0d ticks %0d",
                                       got.rpm, got.position, got.tick_total));
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (got.rpm !== want.rpm || got.position !== want.position ||
                    got.tick_total !== want.tick_total ||
                    got.speed_valid !== want.speed_valid ||
                    got.overspeed !== want.overspeed) begin
                    note_failure($sformatf(
                        "report %0d: want rpm %0d pos %0d ticks %0d valid %0b over %0b, got rpm %0d pos %0d ticks %0d valid %0b over %0b",
                        reports_checked, want.rpm, want.position, want.tick_total,
                        want.speed_valid, want.overspeed, got.rpm, got.position,
                        got.tick_total, got.speed_valid, got.overspeed));
                end
                if (want.speed_valid) begin
                    full_window_reports++;
                end
                if (want.overspeed) begin
                    overspeed_reports++;
                end
                if (int'(want.rpm) > peak_rpm) begin
                    peak_rpm = int'(want.rpm);
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] ERROR: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("encoder_speed_position_top regression: fail");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, then random phases per setting.
    initial begin
        int                        row;
        int                        ph;
        int                        target;
        logic [esp_pkg::CPR_W-1:0] next_cpr;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_cmd        = 1'b0;
        i_phase_b    = 1'b0;
        i_time_ms    = '0;
        i_out_stall  = 1'b0;
        steady       = 1'b0;
        quiet_cycles = 0;
        ring_slot    = 0;
        ring_fill    = 0;
        shaft_ticks  = '0;
        cpr_setting  = esp_pkg::CPR_RESET;
        settings_used = 1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (row = 0; row < $size(DIRECTED_ROWS); row++) begin
            send_item(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].phase_b,
                      DIRECTED_ROWS[row].time_ms, DIRECTED_ROWS[row].typed,
                      DIRECTED_ROWS[row].want);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle_block();
                case (ph)
                    1:       next_cpr = '1;
                    2:       next_cpr = 12'd1;
                    3:       next_cpr = '0;
                    4:       next_cpr = 12'd2;
                    5:       next_cpr = esp_pkg::CPR_W'($urandom_range(4095, 1));
                    6:       next_cpr = esp_pkg::CPR_RESET;
                    default: next_cpr = esp_pkg::CPR_W'($urandom_range(40, 3));
                endcase
                write_cpr(next_cpr);
            end
            steady = (ph == 2);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(9, 0) == 0) begin
                    scatter_noise();
                end else begin
                    spin_burst();
                end
            end
        end
        steady = 1'b0;
        settle_block();

        if (pending_reports.size() != 0) begin
            note_failure($sformatf("%0d reports never arrived", pending_reports.size()));
        end
        $display("Sent %0d transactions under %0d counts-per-rev settings; checked %0d reports.",
                 items_sent, settings_used, reports_checked);
        $display("%0d reports had a full window, %0d overspeed, peak rpm %0d, %0d errors.",
                 full_window_reports, overspeed_reports, peak_rpm, error_count);
        if (error_count == 0) begin
            $display("encoder_speed_position_top regression: pass");
        end else begin
            $display("encoder_speed_position_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/esp_pkg.sv
hdl/esp_front.sv
hdl/esp_div.sv
hdl/esp_back.sv
hdl/encoder_speed_position_top.sv
dv/encoder_speed_position_top_test.sv
